// ----- src/gnbcp_pkg.sv -----
// Shared constants and types for the gated nibble bus capture packer.
package gnbcp_pkg;

  localparam int unsigned SAMPLE_W     = 8;
  localparam int unsigned HELD_W       = 6;
  localparam int unsigned NIBBLE_W     = 4;
  localparam int unsigned NIBBLES      = 16;
  localparam int unsigned WORD_W       = NIBBLE_W * NIBBLES;
  localparam int unsigned PEND_W       = $clog2(NIBBLES);
  localparam int unsigned COUNT_W      = PEND_W + 1;
  localparam int unsigned OUT_DATA_W   = ((WORD_W + COUNT_W + 7) / 8) * 8;

  // Bit positions inside a raw sample
  localparam int unsigned STROBE_BIT   = 4;
  localparam int unsigned BUS_CLK_BIT  = 5;

  typedef enum logic [2:0] {
    PH_SEEK  = 3'b001,
    PH_FRAME = 3'b010,
    PH_DONE  = 3'b100
  } phase_t;

endpackage

// ----- src/gated_nibble_bus_capture_packer.sv -----
// Top level: gated nibble bus capture and 64-bit word packer.
//
//  channel  dir  handshake         payload
//  s_*      in   tvalid/tready     tdata = sample[7:0]; tlast = end_of_capture
//  m_*      out  tvalid/tready     tdata = packed_word[63:0], nibble_count[68:64];
//                                  tlast = frame_last
//
// One sample word per clock: the frame tracking and nibble packing are
// combinational between the slave port and the result register, so a word
// emitted for sample n is on m_* the cycle after it is accepted. Reset (rst,
// sync, active high) returns to frame search and empties the result register.
// s_tready drops only while a result sits unread under a low m_tready.
module gated_nibble_bus_capture_packer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [gnbcp_pkg::SAMPLE_W-1:0]       s_tdata,   // sample[7:0]
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // packed_word[63:0], nibble_count[68:64], zero pad
  output logic [gnbcp_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                 m_tlast
);

  localparam int unsigned WORD_W  = gnbcp_pkg::WORD_W;
  localparam int unsigned COUNT_W = gnbcp_pkg::COUNT_W;
  localparam int unsigned PEND_W  = gnbcp_pkg::PEND_W;
  localparam int unsigned HELD_W  = gnbcp_pkg::HELD_W;
  localparam int unsigned NIB_W   = gnbcp_pkg::NIBBLE_W;
  localparam int unsigned PAD_W   = gnbcp_pkg::OUT_DATA_W - WORD_W - COUNT_W;

  gnbcp_pkg::phase_t   phase, phase_next;
  logic [HELD_W-1:0]   held_sample, held_sample_next;
  logic [WORD_W-1:0]   accumulator, accumulator_next;
  logic [PEND_W-1:0]   pending_count, pending_count_next;

  logic                emit;
  logic [WORD_W-1:0]   emit_word;
  logic [COUNT_W-1:0]  emit_count;
  logic                emit_last;

  logic [WORD_W-1:0]   out_word;
  logic [COUNT_W-1:0]  out_count;

  logic [HELD_W-1:0]   cur;
  logic                strobe;
  logic                eoc;
  logic                fall;
  logic                accept;
  logic [WORD_W-1:0]   merged;
  logic [COUNT_W-1:0]  cnt;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign cur      = s_tdata[HELD_W-1:0];
  assign strobe   = cur[gnbcp_pkg::STROBE_BIT];
  assign eoc      = s_tlast;
  // falling bus clock between held in-frame sample and current one
  assign fall     = held_sample[gnbcp_pkg::BUS_CLK_BIT] && !cur[gnbcp_pkg::BUS_CLK_BIT];

  // drop the held nibble into the slot at pending_count
  always_comb begin
    merged = accumulator;
    for (int i = 0; i < gnbcp_pkg::NIBBLES; i++) begin
      if (fall && (pending_count == PEND_W'(i))) begin
        merged[i*NIB_W +: NIB_W] = held_sample[NIB_W-1:0];
      end
    end
    cnt = {1'b0, pending_count} + COUNT_W'(fall);
  end

  always_comb begin
    phase_next         = phase;
    held_sample_next   = held_sample;
    accumulator_next   = accumulator;
    pending_count_next = pending_count;
    emit               = 1'b0;
    emit_word          = '0;
    emit_count         = '0;
    emit_last          = 1'b0;
    unique case (phase)
      gnbcp_pkg::PH_FRAME: begin
        held_sample_next = cur;
        if (!strobe || eoc) begin
          emit               = 1'b1;
          emit_word          = merged;
          emit_count         = cnt;
          emit_last          = 1'b1;
          accumulator_next   = '0;
          pending_count_next = '0;
          phase_next         = eoc ? gnbcp_pkg::PH_SEEK : gnbcp_pkg::PH_DONE;
        end else if (cnt == COUNT_W'(gnbcp_pkg::NIBBLES)) begin
          emit               = 1'b1;
          emit_word          = merged;
          emit_count         = cnt;
          accumulator_next   = '0;
          pending_count_next = '0;
        end else begin
          accumulator_next   = merged;
          pending_count_next = cnt[PEND_W-1:0];
        end
      end
      gnbcp_pkg::PH_DONE: begin
        if (eoc) begin
          phase_next = gnbcp_pkg::PH_SEEK;
        end
      end
      default: begin
        accumulator_next   = '0;
        pending_count_next = '0;
        phase_next         = gnbcp_pkg::PH_SEEK;
        if (strobe) begin
          held_sample_next = cur;
          if (!eoc) begin
            phase_next = gnbcp_pkg::PH_FRAME;
          end
        end
        // capture ended with no frame open: lone last marker
        if (eoc) begin
          emit      = 1'b1;
          emit_last = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= gnbcp_pkg::PH_SEEK;
      held_sample   <= '0;
      accumulator   <= '0;
      pending_count <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      held_sample   <= held_sample_next;
      accumulator   <= accumulator_next;
      pending_count <= pending_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_word  <= emit_word;
      out_count <= emit_count;
      m_tlast   <= emit_last;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_count, out_word};

endmodule

// ----- sim/tb_gated_nibble_bus_capture_packer.sv -----
// Self-checking testbench for the gated nibble bus capture packer.
module tb_gated_nibble_bus_capture_packer;
  timeunit 1ns;
  timeprecision 1ps;

  import gnbcp_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] count;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic                eoc;
    logic                typed;
    result_t             want;
  } row_t;

  localparam int unsigned N_RANDOM    = 1650;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam result_t     NO_WANT     = '{64'h0, 5'd0, 1'b0};
  localparam result_t     EMPTY_LAST  = '{64'h0, 5'd0, 1'b1};

  // sample, end of capture, typed expectation, expected word
  localparam row_t DIR_ROWS [0:20] = '{
    '{8'h00, 1'b1, 1'b1, EMPTY_LAST},  // capture with no frame, right after reset
    '{8'h1F, 1'b1, 1'b1, EMPTY_LAST},  // one-sample frame
    '{8'h05, 1'b0, 1'b0, NO_WANT},
    '{8'h3A, 1'b0, 1'b0, NO_WANT},     // frame start, clock high
    '{8'h13, 1'b0, 1'b0, NO_WANT},     // falling edge
    '{8'h3F, 1'b0, 1'b0, NO_WANT},
    '{8'h0F, 1'b0, 1'b0, NO_WANT},     // strobe drops on a falling edge
    '{8'hFF, 1'b0, 1'b0, NO_WANT},     // ignored after frame
    '{8'h30, 1'b1, 1'b0, NO_WANT},     // rearm without output
    '{8'hD0, 1'b0, 1'b0, NO_WANT},     // top bits set, frame start
    '{8'h30, 1'b0, 1'b0, NO_WANT},
    '{8'h10, 1'b0, 1'b0, NO_WANT},     // captures a zero nibble
    '{8'h00, 1'b0, 1'b0, NO_WANT},     // all-zero flush
    '{8'h00, 1'b1, 1'b0, NO_WANT},
    '{8'h3C, 1'b0, 1'b0, NO_WANT},
    '{8'h17, 1'b1, 1'b0, NO_WANT},     // end of capture in frame, own nibble dropped
    '{8'h35, 1'b0, 1'b0, NO_WANT},
    '{8'h25, 1'b0, 1'b1, EMPTY_LAST},  // frame ends with nothing pending
    '{8'h00, 1'b1, 1'b0, NO_WANT},
    '{8'h80, 1'b0, 1'b0, NO_WANT},
    '{8'hC0, 1'b1, 1'b1, EMPTY_LAST}
  };

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata  = '0;
  logic                  s_tlast  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  // predictor state
  logic [HELD_W-1:0] trk_held  = '0;
  phase_t            trk_phase = PH_SEEK;
  logic [WORD_W-1:0] trk_acc   = '0;
  logic [PEND_W-1:0] trk_pend  = '0;

  result_t words_due[$];
  bit      no_gaps      = 1'b0;
  int      n_sent       = 0;
  int      n_errors     = 0;
  int      n_words      = 0;
  int      n_frames     = 0;
  int      n_empty      = 0;
  int      n_full       = 0;
  int      n_full_last  = 0;
  int      cycle_count  = 0;

  gated_nibble_bus_capture_packer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Advances the frame tracker by one sample; returns 1 when a word is due.
  function automatic bit capture_step(input logic [SAMPLE_W-1:0] smp, input logic eoc,
                                      output result_t res);
    logic [HELD_W-1:0]  s;
    logic [COUNT_W-1:0] cnt;
    logic [WORD_W-1:0]  w;
    logic               strobe;
    s = smp[HELD_W-1:0];
    strobe = s[STROBE_BIT];
    res = NO_WANT;
    capture_step = 1'b0;
    case (trk_phase)
      PH_FRAME: begin
        cnt = {1'b0, trk_pend};
        w = trk_acc;
        if (trk_held[BUS_CLK_BIT] && !s[BUS_CLK_BIT]) begin
          w |= 64'(trk_held[NIBBLE_W-1:0]) << (NIBBLE_W * cnt);
          cnt++;
        end
        trk_held = s;
        if (!strobe || eoc) begin
          res = '{w, cnt, 1'b1};
          capture_step = 1'b1;
          trk_acc = '0;
          trk_pend = '0;
          trk_phase = eoc ? PH_SEEK : PH_DONE;
        end else if (cnt == NIBBLES) begin
          res = '{w, cnt, 1'b0};
          capture_step = 1'b1;
          trk_acc = '0;
          trk_pend = '0;
        end else begin
          trk_acc = w;
          trk_pend = cnt[PEND_W-1:0];
        end
      end
      PH_DONE: begin
        if (eoc) trk_phase = PH_SEEK;
      end
      default: begin
        trk_acc = '0;
        trk_pend = '0;
        if (strobe) trk_held = s;
        trk_phase = (strobe && !eoc) ? PH_FRAME : PH_SEEK;
        if (eoc) begin
          res = EMPTY_LAST;
          capture_step = 1'b1;
        end
      end
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic eoc,
                             input logic typed = 1'b0, input result_t want = NO_WANT);
    result_t res;
    bit      got;
    no_gaps = (n_sent >= 700 && n_sent < 1000);
    while (!no_gaps && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= eoc;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
    got = capture_step(smp, eoc, res);
    if (typed) words_due.push_back(want);
    else if (got) words_due.push_back(res);
  endtask

  // One capture buffer: idle lead-in, a strobed frame, then any trailing samples.
  task automatic send_capture();
    int   lead, flen, tail, sel;
    bit   toggle, lvl, eoc_in_frame;
    logic bclk;
    lead = $urandom_range(3);
    sel = $urandom_range(9);
    if (sel <= 5) flen = $urandom_range(1, 12);
    else if (sel <= 7) flen = $urandom_range(31, 33);  // sixteenth nibble near frame end
    else if (sel == 8) flen = $urandom_range(13, 30);
    else flen = $urandom_range(34, 70);
    toggle = ($urandom_range(3) != 0);
    lvl = $urandom_range(1);
    eoc_in_frame = ($urandom_range(3) == 0);
    tail = $urandom_range(3);
    for (int k = 0; k < lead; k++)
      send_sample({2'($urandom), 1'($urandom), 1'b0, 4'($urandom)}, 1'b0);
    for (int k = 0; k < flen; k++) begin
      bclk = toggle ? lvl : 1'($urandom);
      lvl = ~lvl;
      send_sample({2'($urandom), bclk, 1'b1, 4'($urandom)}, eoc_in_frame && k == flen - 1);
    end
    if (!eoc_in_frame) begin
      bclk = toggle ? lvl : 1'($urandom);
      send_sample({2'($urandom), bclk, 1'b0, 4'($urandom)}, tail == 0);
      for (int k = 0; k < tail; k++)
        send_sample(8'($urandom), k == tail - 1);
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t got, exp;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[WORD_W-1:0], m_tdata[WORD_W +: COUNT_W], m_tlast};
        n_words++;
        if (got.last) n_frames++;
        if (got.last && got.count == 0) n_empty++;
        if (got.count == NIBBLES) n_full++;
        if (got.count == NIBBLES && got.last) n_full_last++;
        if (words_due.size() == 0) begin
          $display("%0t: unexpected word %h count %0d last %0b",
                   $time, got.word, got.count, got.last);
          n_errors++;
        end else begin
          exp = words_due.pop_front();
          if (got.word !== exp.word) begin
            $display("%0t: packed_word expected %h got %h", $time, exp.word, got.word);
            n_errors++;
          end
          if (got.count !== exp.count) begin
            $display("%0t: nibble_count expected %0d got %0d", $time, exp.count, got.count);
            n_errors++;
          end
          if (got.last !== exp.last) begin
            $display("%0t: frame_last expected %0b got %0b", $time, exp.last, got.last);
            n_errors++;
          end
        end
      end
      m_tready <= no_gaps || ($urandom_range(99) >= 15);
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL gated_nibble_bus_capture_packer");
    $finish;
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (DIR_ROWS[i])
      send_sample(DIR_ROWS[i].smp, DIR_ROWS[i].eoc, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    while (n_sent < $size(DIR_ROWS) + N_RANDOM) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 5)) send_sample(8'($urandom), $urandom_range(7) == 0);
      end else begin
        send_capture();
      end
    end
    s_tvalid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Sent %0d samples; checked %0d words, %0d frame ends (%0d empty).",
             n_sent, n_words, n_frames, n_empty);
    $display("Full 16-nibble words: %0d, of which %0d closed a frame.", n_full, n_full_last);
    if (n_errors == 0) begin
      $display("PASS gated_nibble_bus_capture_packer");
    end else begin
      $display("FAIL gated_nibble_bus_capture_packer");
    end
    $finish;
  end

endmodule
